### src/lctmw_pkg.sv
// ----------------------------------------------------------------------------
// lctmw_pkg
// Widths, reset values, register indexes, sequencer states and status types
// shared by the trimmed-mean weigher.
// ----------------------------------------------------------------------------
package lctmw_pkg;

  localparam int CNT_W  = 24;
  localparam int WT_W   = 17;
  localparam int REF_W  = 16;
  localparam int DIFF_W = CNT_W + 1;
  localparam int PROD_W = DIFF_W + REF_W;
  localparam int ITER_W = $clog2(PROD_W + 1);
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [WT_W-1:0] WEIGHT_MAX  = 17'd99999;
  localparam logic [WT_W-1:0] STABLE_SPAN = 17'd4;

  localparam logic signed [CNT_W-1:0] ZERO_LEVEL_RST = 24'sd478191;
  localparam logic signed [CNT_W-1:0] LEVEL_ONE_RST  = 24'sd568495;
  localparam logic signed [CNT_W-1:0] LEVEL_TWO_RST  = 24'sd659005;
  localparam logic [REF_W-1:0]        REF_WEIGHT_RST = 16'd1000;

  typedef enum logic [1:0] {
    REG_ZERO_LEVEL,
    REG_LEVEL_ONE,
    REG_LEVEL_TWO,
    REG_REF_WEIGHT
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM,
    ST_DIV1_GO,
    ST_DIV1,
    ST_PREP,
    ST_MUL_GO,
    ST_MUL,
    ST_DIV2_GO,
    ST_DIV2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic stable;
    logic newly_stable;
  } hist_stat_t;

endpackage

### src/lctmw_window.sv
// ----------------------------------------------------------------------------
// lctmw_window
// Sample window shift line. After a push it rotates once through all entries,
// one per cycle, accumulating the sum, the signed maximum and the minimum.
// ----------------------------------------------------------------------------
module lctmw_window #(
  parameter int WINDOW = 8,
  parameter int SUM_W  = 28
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic signed [lctmw_pkg::CNT_W-1:0]   sample,
  output logic                                 done,
  output logic signed [SUM_W-1:0]              sum,
  output logic signed [lctmw_pkg::CNT_W-1:0]   hi,
  output logic signed [lctmw_pkg::CNT_W-1:0]   lo
);
  import lctmw_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);

  logic signed [CNT_W-1:0] win [WINDOW];
  logic signed [CNT_W-1:0] tail;
  logic                    busy;
  logic [IDX_W-1:0]        cnt;

  assign tail = win[WINDOW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        win[i] <= '0;
      end
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (push) begin
        win[0] <= sample;
        for (int i = 1; i < WINDOW; i++) begin
          win[i] <= win[i-1];
        end
        busy <= 1'b1;
        cnt  <= '0;
        sum  <= '0;
        hi   <= sample;
        lo   <= sample;
      end else if (busy) begin
        win[0] <= tail;
        for (int i = 1; i < WINDOW; i++) begin
          win[i] <= win[i-1];
        end
        sum <= sum + SUM_W'(tail);
        if (tail > hi) begin
          hi <= tail;
        end
        if (tail < lo) begin
          lo <= tail;
        end
        cnt <= cnt + 1'b1;
        if (cnt == IDX_W'(WINDOW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/lctmw_sermul.sv
// ----------------------------------------------------------------------------
// lctmw_sermul
// Bit-serial unsigned shift-add multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lctmw_sermul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [lctmw_pkg::DIFF_W-1:0]        a,
  input  logic [lctmw_pkg::REF_W-1:0]         b,
  output logic                                busy,
  output logic                                done,
  output logic [lctmw_pkg::PROD_W-1:0]        prod
);
  import lctmw_pkg::*;

  localparam int BIT_W = $clog2(REF_W + 1);

  logic [PROD_W:0]   acc;
  logic [DIFF_W:0]   part;
  logic [BIT_W-1:0]  left;

  assign part = acc[PROD_W:REF_W] + (acc[0] ? {1'b0, a} : '0);
  assign prod = acc[PROD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= {{(DIFF_W + 1){1'b0}}, b};
        left <= BIT_W'(REF_W);
        busy <= 1'b1;
      end else if (busy) begin
        acc  <= {1'b0, part, acc[REF_W-1:1]};
        left <= left - 1'b1;
        if (left == BIT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/lctmw_serdiv.sv
// ----------------------------------------------------------------------------
// lctmw_serdiv
// Bit-serial restoring divider on magnitudes, one quotient bit per cycle.
// The numerator is left-aligned; after iters steps the quotient sits in the
// low iters bits.
// ----------------------------------------------------------------------------
module lctmw_serdiv (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [lctmw_pkg::PROD_W-1:0]      num,
  input  logic [lctmw_pkg::DIFF_W-1:0]      den,
  input  logic [lctmw_pkg::ITER_W-1:0]      iters,
  output logic                              busy,
  output logic                              done,
  output logic [lctmw_pkg::PROD_W-1:0]      quo
);
  import lctmw_pkg::*;

  logic [DIFF_W-1:0] rem;
  logic [DIFF_W:0]   shifted;
  logic [DIFF_W+1:0] trial;
  logic [ITER_W-1:0] left;

  assign shifted = {rem, quo[PROD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= num;
        rem  <= '0;
        left <= iters;
        busy <= 1'b1;
      end else if (busy) begin
        if (trial[DIFF_W+1]) begin
          rem <= shifted[DIFF_W-1:0];
          quo <= {quo[PROD_W-2:0], 1'b0};
        end else begin
          rem <= trial[DIFF_W-1:0];
          quo <= {quo[PROD_W-2:0], 1'b1};
        end
        left <= left - 1'b1;
        if (left == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/lctmw_history.sv
// ----------------------------------------------------------------------------
// lctmw_history
// Weight history shift line and stability detector.
// ----------------------------------------------------------------------------
module lctmw_history #(
  parameter int HISTORY = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic [lctmw_pkg::WT_W-1:0]        weight,
  output lctmw_pkg::hist_stat_t             stat
);
  import lctmw_pkg::*;

  logic [WT_W-1:0] hist [HISTORY];
  logic [WT_W-1:0] oldest;
  logic [WT_W:0]   upper;
  logic            was_stable;

  // entry that becomes the oldest once the new weight is pushed
  assign oldest = hist[HISTORY-2];
  assign upper  = {1'b0, oldest} + {1'b0, STABLE_SPAN};

  assign stat.stable       = (weight >= oldest) && ({1'b0, weight} <= upper);
  assign stat.newly_stable = stat.stable && !was_stable;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY; i++) begin
        hist[i] <= '0;
      end
      was_stable <= 1'b0;
    end else if (push) begin
      hist[0] <= weight;
      for (int i = 1; i < HISTORY; i++) begin
        hist[i] <= hist[i-1];
      end
      was_stable <= stat.stable;
    end
  end

endmodule

### src/load_cell_trimmed_mean_weigher.sv
// ----------------------------------------------------------------------------
// load_cell_trimmed_mean_weigher
// Trimmed-mean filter, two-point scale calibration and stability detector.
//
// Input channel (in_valid/in_ready, raw_count) takes one converter count per
// item; the output channel (out_valid/out_ready) returns one result per item:
// filtered_count, weight, stable and newly_stable. Calibration registers sit
// on the APB port: 0x0 zero_level, 0x4 level_one, 0x8 level_two,
// 0xC reference_weight; write them only while no item is in flight.
// One item is processed at a time: a window scan of one entry per cycle, two
// bit-serial divisions (trimmed sum, then weight) and a bit-serial multiply.
// The result waits in an output register; the next item is accepted while it
// waits, but its own result is held back until the previous one is taken.
// Reset clears the window, the history and the stability flag to zero and
// loads the calibration defaults.
// ----------------------------------------------------------------------------
module load_cell_trimmed_mean_weigher #(
  parameter int WINDOW  = 8,
  parameter int HISTORY = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [lctmw_pkg::CNT_W-1:0]   raw_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lctmw_pkg::CNT_W-1:0]   filtered_count,
  output logic [lctmw_pkg::WT_W-1:0]           weight,
  output logic                                 stable,
  output logic                                 newly_stable,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lctmw_pkg::ADDR_W-1:0]         paddr,
  input  logic [lctmw_pkg::DATA_W-1:0]         pwdata,
  output logic [lctmw_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);
  import lctmw_pkg::*;

  localparam int SUM_W = CNT_W + $clog2(WINDOW) + 1;

  state_t state, state_next;

  logic signed [CNT_W-1:0]  zero_level;
  logic signed [CNT_W-1:0]  level_one;
  logic signed [CNT_W-1:0]  level_two;
  logic [REF_W-1:0]         reference_weight;

  logic signed [SUM_W-1:0]  trim;
  logic signed [CNT_W-1:0]  filt;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] span;
  logic [WT_W-1:0]          wt;

  logic [SUM_W-1:0]         trim_mag;
  logic [DIFF_W-1:0]        diff_mag;
  logic [DIFF_W-1:0]        span_mag;
  logic                     over;

  logic                     win_push;
  logic                     win_done;
  logic signed [SUM_W-1:0]  win_sum;
  logic signed [CNT_W-1:0]  win_hi;
  logic signed [CNT_W-1:0]  win_lo;

  logic                     mul_start;
  logic                     mul_busy;
  logic                     mul_done;
  logic [PROD_W-1:0]        prod;

  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [PROD_W-1:0]        div_num;
  logic [DIFF_W-1:0]        div_den;
  logic [ITER_W-1:0]        div_iters;
  logic [PROD_W-1:0]        quo;

  logic                     hist_push;
  hist_stat_t               hist_stat;

  logic                     cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_level       <= ZERO_LEVEL_RST;
      level_one        <= LEVEL_ONE_RST;
      level_two        <= LEVEL_TWO_RST;
      reference_weight <= REF_WEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_ZERO_LEVEL: zero_level       <= $signed(pwdata[CNT_W-1:0]);
        REG_LEVEL_ONE:  level_one        <= $signed(pwdata[CNT_W-1:0]);
        REG_LEVEL_TWO:  level_two        <= $signed(pwdata[CNT_W-1:0]);
        REG_REF_WEIGHT: reference_weight <= pwdata[REF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_ZERO_LEVEL: prdata = {{(DATA_W - CNT_W){1'b0}}, zero_level};
      REG_LEVEL_ONE:  prdata = {{(DATA_W - CNT_W){1'b0}}, level_one};
      REG_LEVEL_TWO:  prdata = {{(DATA_W - CNT_W){1'b0}}, level_two};
      REG_REF_WEIGHT: prdata = {{(DATA_W - REF_W){1'b0}}, reference_weight};
      default:        prdata = '0;
    endcase
  end

  // units
  lctmw_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .push   (win_push),
    .sample (raw_count),
    .done   (win_done),
    .sum    (win_sum),
    .hi     (win_hi),
    .lo     (win_lo)
  );

  lctmw_sermul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (diff_mag),
    .b     (reference_weight),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  lctmw_serdiv u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  lctmw_history #(
    .HISTORY (HISTORY)
  ) u_history (
    .clk    (clk),
    .rst    (rst),
    .push   (hist_push),
    .weight (wt),
    .stat   (hist_stat)
  );

  // operand selection
  assign trim_mag = trim[SUM_W-1] ? SUM_W'(-trim) : SUM_W'(trim);
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign span_mag = span[DIFF_W-1] ? DIFF_W'(-span) : DIFF_W'(span);
  assign over     = (|quo[PROD_W-1:WT_W]) || (quo[WT_W-1:0] > WEIGHT_MAX);

  always_comb begin
    if (state inside {ST_DIV1_GO, ST_DIV1}) begin
      div_num   = {trim_mag, {(PROD_W - SUM_W){1'b0}}};
      div_den   = DIFF_W'(WINDOW - 2);
      div_iters = ITER_W'(SUM_W);
    end else begin
      div_num   = prod;
      div_den   = span_mag;
      div_iters = ITER_W'(PROD_W);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_SCAN;
      ST_SCAN:    if (win_done) state_next = ST_TRIM;
      ST_TRIM:    state_next = ST_DIV1_GO;
      ST_DIV1_GO: state_next = ST_DIV1;
      ST_DIV1:    if (div_done) state_next = ST_PREP;
      ST_PREP:    state_next = ST_MUL_GO;
      ST_MUL_GO:  state_next = ST_MUL;
      ST_MUL:     if (mul_done) state_next = ST_DIV2_GO;
      ST_DIV2_GO: state_next = ST_DIV2;
      ST_DIV2:    if (div_done) state_next = ST_DONE;
      ST_DONE:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    mul_start = (state == ST_MUL_GO);
    div_start = (state == ST_DIV1_GO) || (state == ST_DIV2_GO);
    hist_push = (state == ST_DONE) && (!out_valid || out_ready);
  end

  assign win_push = in_valid && in_ready;

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_TRIM) begin
      trim <= win_sum - SUM_W'(win_hi) - SUM_W'(win_lo);
    end
    if (state == ST_DIV1 && div_done) begin
      filt <= trim[SUM_W-1] ? -$signed(quo[CNT_W-1:0]) : $signed(quo[CNT_W-1:0]);
    end
    if (state == ST_PREP) begin
      diff <= DIFF_W'(filt) - DIFF_W'(zero_level);
      span <= DIFF_W'(level_two) - DIFF_W'(level_one);
    end
    if (state == ST_DIV2 && div_done) begin
      if (span == '0 || (diff[DIFF_W-1] ^ span[DIFF_W-1]) || over) begin
        wt <= '0;
      end else begin
        wt <= quo[WT_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hist_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_push) begin
      filtered_count <= filt;
      weight         <= wt;
      stable         <= hist_stat.stable;
      newly_stable   <= hist_stat.newly_stable;
    end
  end

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> weight <= WEIGHT_MAX)
    else $error("weight above range");

  a_newly_implies_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!newly_stable || stable))
    else $error("newly_stable without stable");

  a_units_quiet_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> (!div_busy && !mul_busy && !win_done))
    else $error("arithmetic unit active while idle");

  a_scan_done_place: assert property (@(posedge clk) disable iff (rst)
    win_done |-> state == ST_SCAN)
    else $error("window scan finished outside scan state");

  a_push_frees_output: assert property (@(posedge clk) disable iff (rst)
    hist_push |=> out_valid && $past(state) == ST_DONE)
    else $error("result loaded without output");

endmodule

### sim/load_cell_trimmed_mean_weigher_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// load_cell_trimmed_mean_weigher_test
// Self-checking bench for the trimmed-mean weigher. A queue of converter
// counts feeds a valid/ready driver. An in-bench model of the filter, the
// calibration and the stability detector predicts every result. A monitor
// compares each result field by field. Calibration is rewritten over APB
// between phases while the block is drained. Directed extremes come first,
// then load runs with random content and random counts.
// ----------------------------------------------------------------------------
module load_cell_trimmed_mean_weigher_test;
  import lctmw_pkg::*;

  localparam int WIN_DEPTH   = 8;
  localparam int HIST_DEPTH  = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_CYCLES = 110;

  typedef struct packed {
    logic signed [CNT_W-1:0] filtered;
    logic [WT_W-1:0]         wt;
    logic                    stab;
    logic                    fresh;
  } weighing_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [CNT_W-1:0] raw_count = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [CNT_W-1:0] filtered_count;
  logic [WT_W-1:0]         weight;
  logic                    stable;
  logic                    newly_stable;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  logic signed [CNT_W-1:0] pending_counts [$];
  weighing_t               expected_weighings [$];

  logic signed [CNT_W-1:0] window_counts [WIN_DEPTH];
  logic [WT_W-1:0]         recent_weights [HIST_DEPTH];
  logic                    stable_before = 1'b0;
  logic signed [CNT_W-1:0] cfg_zero_level = ZERO_LEVEL_RST;
  logic signed [CNT_W-1:0] cfg_level_one  = LEVEL_ONE_RST;
  logic signed [CNT_W-1:0] cfg_level_two  = LEVEL_TWO_RST;
  logic [REF_W-1:0]        cfg_ref_weight = REF_WEIGHT_RST;

  int  send_idle_pct = 15;
  int  recv_idle_pct = 63;
  int  failures = 0;
  int  cycle_count = 0;
  bit  in_fire = 1'b0;
  bit  hold_for_drain = 1'b0;

  load_cell_trimmed_mean_weigher #(
    .WINDOW (WIN_DEPTH),
    .HISTORY(HIST_DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .raw_count     (raw_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .filtered_count(filtered_count),
    .weight        (weight),
    .stable        (stable),
    .newly_stable  (newly_stable),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  function automatic weighing_t weigh_sample(input logic signed [CNT_W-1:0] sample);
    weighing_t               r;
    longint                  sum;
    longint                  hi;
    longint                  lo;
    longint                  span;
    longint                  w;
    logic signed [CNT_W-1:0] filt;
    logic [WT_W-1:0]         oldest;
    for (int i = WIN_DEPTH - 1; i > 0; i--) window_counts[i] = window_counts[i-1];
    window_counts[0] = sample;
    sum = 0;
    hi = sample;
    lo = sample;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (window_counts[i] > hi) hi = window_counts[i];
      if (window_counts[i] < lo) lo = window_counts[i];
      sum += window_counts[i];
    end
    filt = CNT_W'((sum - hi - lo) / (WIN_DEPTH - 2));
    span = longint'(cfg_level_two) - longint'(cfg_level_one);
    if (span == 0) begin
      w = 0;
    end else begin
      w = (longint'(filt) - longint'(cfg_zero_level)) * longint'(cfg_ref_weight) / span;
    end
    if (w < 0 || w > longint'(WEIGHT_MAX)) w = 0;
    for (int i = HIST_DEPTH - 1; i > 0; i--) recent_weights[i] = recent_weights[i-1];
    recent_weights[0] = WT_W'(w);
    oldest = recent_weights[HIST_DEPTH-1];
    r.filtered = filt;
    r.wt = WT_W'(w);
    r.stab = (r.wt >= oldest) && (int'(r.wt) <= int'(oldest) + int'(STABLE_SPAN));
    r.fresh = r.stab && !stable_before;
    stable_before = r.stab;
    return r;
  endfunction

  function automatic logic signed [CNT_W-1:0] clamp_count(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return CNT_W'(v);
  endfunction

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= 10) $display("ERROR: %s", msg);
  endtask

  // accept and predict
  always @(posedge clk) begin
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) expected_weighings.push_back(weigh_sample(raw_count));
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (hold_for_drain && expected_weighings.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_counts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        raw_count <= pending_counts.pop_front();
        hold_for_drain <= ($urandom_range(63) == 0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    weighing_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_weighings.size() == 0) begin
        log_failure($sformatf("unexpected result filtered=%0d weight=%0d",
                              filtered_count, weight));
      end else begin
        exp_r = expected_weighings.pop_front();
        if (filtered_count !== exp_r.filtered || weight !== exp_r.wt ||
            stable !== exp_r.stab || newly_stable !== exp_r.fresh) begin
          log_failure($sformatf(
            "exp filt=%0d wt=%0d st=%0b new=%0b got filt=%0d wt=%0d st=%0b new=%0b",
            exp_r.filtered, exp_r.wt, exp_r.stab, exp_r.fresh,
            filtered_count, weight, stable, newly_stable));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("load_cell_trimmed_mean_weigher verification failed");
      $finish;
    end
  end

  task automatic wait_for_idle();
    while (pending_counts.size() != 0 || in_valid || expected_weighings.size() != 0)
      @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [CNT_W-1:0] value);
    logic [DATA_W-1:0] data;
    data = {$urandom()};
    data[CNT_W-1:0] = value;
    if (idx == REG_REF_WEIGHT) data[CNT_W-1:REF_W] = (CNT_W - REF_W)'($urandom());
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ZERO_LEVEL: cfg_zero_level = data[CNT_W-1:0];
      REG_LEVEL_ONE:  cfg_level_one = data[CNT_W-1:0];
      REG_LEVEL_TWO:  cfg_level_two = data[CNT_W-1:0];
      REG_REF_WEIGHT: cfg_ref_weight = data[REF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic calibrate(input longint zero, input longint one, input longint two,
                           input logic [REF_W-1:0] ref_units);
    wait_for_idle();
    apb_write(REG_ZERO_LEVEL, CNT_W'(zero));
    apb_write(REG_LEVEL_ONE, CNT_W'(one));
    apb_write(REG_LEVEL_TWO, CNT_W'(two));
    apb_write(REG_REF_WEIGHT, {8'h00, ref_units});
  endtask

  task automatic random_calibration();
    longint one;
    longint span;
    one = longint'($urandom_range(6000000)) - 3000000;
    span = longint'($urandom_range(500000, 1000));
    if ($urandom_range(1)) span = -span;
    calibrate(longint'($urandom_range(4000000)) - 2000000, one, one + span,
              REF_W'($urandom_range(65535, 1)));
  endtask

  // load runs: steady counts near a target weight, plus noise items
  task automatic queue_load_runs(input int n_items);
    int     queued;
    int     run_len;
    longint span;
    longint base;
    longint amp;
    queued = 0;
    span = longint'(cfg_level_two) - longint'(cfg_level_one);
    while (queued < n_items) begin
      if ($urandom_range(99) < 15) begin
        pending_counts.push_back(CNT_W'($urandom()));
        queued++;
      end else begin
        if (cfg_ref_weight == 0 || span == 0) begin
          base = longint'($urandom_range(16777215)) - 8388608;
        end else begin
          base = longint'(cfg_zero_level) +
                 longint'($urandom_range(110000)) * span / longint'(cfg_ref_weight);
        end
        case ($urandom_range(4))
          0: amp = 0;
          1: amp = 2;
          2: amp = 40;
          3: amp = 800;
          default: amp = 30000;
        endcase
        run_len = $urandom_range(24, 10);
        for (int i = 0; i < run_len; i++)
          pending_counts.push_back(clamp_count(base +
                                   longint'($urandom_range(2 * amp)) - amp));
        queued += run_len;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < WIN_DEPTH; i++) window_counts[i] = '0;
    for (int i = 0; i < HIST_DEPTH; i++) recent_weights[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset contents, count extremes, steady and heavy loads
    pending_counts.push_back(24'sd0);
    pending_counts.push_back(24'sd0);
    repeat (3) pending_counts.push_back(24'sh7FFFFF);
    repeat (3) pending_counts.push_back(24'sh800000);
    pending_counts.push_back(-24'sd1);
    pending_counts.push_back(24'sd1);
    repeat (8) pending_counts.push_back(24'sd600000);
    repeat (3) pending_counts.push_back(24'sh7FFFFF);

    // equal levels
    calibrate(-8388608, 8388607, 8388607, 16'd65535);
    pending_counts.push_back(24'sh7FFFFF);
    pending_counts.push_back(24'sh800000);
    pending_counts.push_back(24'sd0);
    pending_counts.push_back(24'sd12345);

    random_calibration();
    queue_load_runs(110);

    calibrate(0, 0, 0, 16'd0);
    send_idle_pct = 63;
    recv_idle_pct = 15;
    calibrate(8388607, -8388608, 8388607, 16'd65535);
    queue_load_runs(60);
    random_calibration();
    queue_load_runs(110);
    // zero reference weight
    calibrate(-8388608, 0, 1, 16'd0);
    queue_load_runs(40);

    wait_for_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_calibration();
    queue_load_runs(140);
    random_calibration();
    queue_load_runs(140);
    calibrate(ZERO_LEVEL_RST, LEVEL_ONE_RST, LEVEL_TWO_RST, REF_WEIGHT_RST);
    queue_load_runs(60);

    wait_for_idle();
    repeat (2 * ITEM_CYCLES) @(posedge clk);
    if (expected_weighings.size() != 0)
      log_failure($sformatf("%0d results never arrived", expected_weighings.size()));
    if (failures == 0) begin
      $display("load_cell_trimmed_mean_weigher verification clean");
    end else begin
      $display("load_cell_trimmed_mean_weigher verification failed");
    end
    $finish;
  end

endmodule
